// ----- hdl/rabb_pkg.sv -----
// Shared types and constants for the ray versus box slab intersection block.
package rabb_pkg;

   // Coordinate and result field widths.
   localparam int COORD_W   = 32;
   localparam int DIST_W    = 31;
   localparam int OUTCOME_W = 2;

   // Configuration port.
   localparam int CSR_IDX_W = 3;
   localparam int NUM_CSR   = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z = 3'd5;

   // Outcome codes.
   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT    = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_BEHIND = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_MISS   = 2'd2;

   // Internal datapath widths.
   localparam int MAG_W     = 30;             // prescaled direction magnitude
   localparam int SQR_W     = 2 * MAG_W;      // one squared component
   localparam int SUM_W     = SQR_W + 2;      // sum of three squares
   localparam int LEN_W     = 31;             // direction length
   localparam int NRM_W     = 31;             // normal component, Q1.30, at most 2^30
   localparam int INV_W     = 61;             // reciprocal, at most 2^60
   localparam int INV_LO_W  = 31;             // low slice of the reciprocal
   localparam int DIFF_W    = COORD_W + 1;    // box minus origin
   localparam int PPL_W     = DIFF_W + INV_LO_W;
   localparam int PPH_W     = DIFF_W + INV_W - INV_LO_W;
   localparam int FRAC_W    = 30;             // scaling of the reciprocal
   localparam int T_W       = 64;             // signed slab distance
   localparam int SQ_STEPS  = SUM_W / 2;      // square root result bits
   localparam int DIV_STEPS = NRM_W;          // normal quotient bits
   localparam int RCP_STEPS = INV_W;          // reciprocal quotient bits

   localparam logic [INV_W-1:0] RECIP_SAT = INV_W'(1) << (INV_W - 1);
   localparam logic [T_W-1:0]   T_SAT     = T_W'(1) << (T_W - 2);
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // One ray request.
   typedef struct packed {
      logic signed [COORD_W-1:0] ray_origin_x;
      logic signed [COORD_W-1:0] ray_origin_y;
      logic signed [COORD_W-1:0] ray_origin_z;
      logic signed [COORD_W-1:0] ray_dir_x;
      logic signed [COORD_W-1:0] ray_dir_y;
      logic signed [COORD_W-1:0] ray_dir_z;
   } ray_req_type;

   // One intersection result.
   typedef struct packed {
      logic                  hit;
      logic [OUTCOME_W-1:0]  outcome;
      logic [DIST_W-1:0]     hit_distance;
   } ray_rsp_type;

endpackage

// ----- hdl/ray_aabb_slab_intersect.sv -----
// Pipelined ray versus axis-aligned box slab test in Q16.16 fixed point.

// Each request carries a ray origin and an unnormalized direction; the block
// normalizes the direction, takes per-axis reciprocals, computes six slab
// distances against the box in the corner registers and returns one result:
// hit with the entry distance, entry behind the origin, or no slab overlap.
// The pipeline takes one request per cycle while the result side does not
// stall, and each result passes the prescale stages, the bit-per-stage square
// root (31 stages), the normal divider (31 stages), the reciprocal divider
// (61 stages) and the multiply and compare stages. A stall on the result side
// holds the whole pipeline. The user must write the box registers only while
// no request is in flight; the block itself does not enforce this.
module ray_aabb_slab_intersect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rabb_pkg::ray_req_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rabb_pkg::ray_rsp_type               rsp_data,
   input  logic                                csr_wr_en,
   input  logic [rabb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rabb_pkg::COORD_W-1:0]        csr_wr_data
);

   // Side data that travels with a request through the long sections.
   typedef struct packed {
      logic [2:0][rabb_pkg::COORD_W-1:0] org;
      logic [2:0]                        neg;
      logic                              zero;
   } side_type;

   logic adv;
   logic req_take;

   // Box corner registers.
   logic [rabb_pkg::COORD_W-1:0] box_ff [0:rabb_pkg::NUM_CSR-1];

   // Front stages.
   logic                                     s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   side_type                                 s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff;
   logic [2:0][rabb_pkg::COORD_W-1:0]        s1_mag_ff, s2_mag_ff;
   logic [rabb_pkg::COORD_W-1:0]             s2_big_ff;
   logic [2:0][rabb_pkg::MAG_W-1:0]          s3_mag_ff, s4_mag_ff;
   logic [2:0][rabb_pkg::SQR_W-1:0]          s4_sq_ff;
   side_type                                 s1_side_in;
   side_type                                 s2_side_in;
   logic [2:0][rabb_pkg::COORD_W-1:0]        s1_mag_in;
   logic [rabb_pkg::COORD_W-1:0]             s2_big_in;
   logic [2:0][rabb_pkg::MAG_W-1:0]          s3_mag_in;
   logic [4:0]                               msb_pos;

   // Square root section.
   logic                                     sq_vld_ff  [0:rabb_pkg::SQ_STEPS];
   logic [rabb_pkg::SUM_W-1:0]               sq_x_ff    [0:rabb_pkg::SQ_STEPS];
   logic [rabb_pkg::SUM_W-1:0]               sq_res_ff  [0:rabb_pkg::SQ_STEPS];
   logic [2:0][rabb_pkg::MAG_W-1:0]          sq_mag_ff  [0:rabb_pkg::SQ_STEPS];
   side_type                                 sq_side_ff [0:rabb_pkg::SQ_STEPS];

   // Normal divider section.
   logic                                     dv_vld_ff  [0:rabb_pkg::DIV_STEPS];
   logic [2:0][rabb_pkg::LEN_W-1:0]          dv_rem_ff  [0:rabb_pkg::DIV_STEPS];
   logic [2:0][rabb_pkg::NRM_W-1:0]          dv_q_ff    [0:rabb_pkg::DIV_STEPS];
   logic [rabb_pkg::LEN_W-1:0]               dv_len_ff  [0:rabb_pkg::DIV_STEPS];
   side_type                                 dv_side_ff [0:rabb_pkg::DIV_STEPS];
   logic [2:0]                               dv_lsb_ff;

   // Reciprocal divider section.
   logic                                     rc_vld_ff  [0:rabb_pkg::RCP_STEPS];
   logic [2:0][rabb_pkg::NRM_W-1:0]          rc_rem_ff  [0:rabb_pkg::RCP_STEPS];
   logic [2:0][rabb_pkg::INV_W-1:0]          rc_q_ff    [0:rabb_pkg::RCP_STEPS];
   logic [2:0][rabb_pkg::NRM_W-1:0]          rc_div_ff  [0:rabb_pkg::RCP_STEPS];
   logic [2:0]                               rc_sat_ff  [0:rabb_pkg::RCP_STEPS];
   side_type                                 rc_side_ff [0:rabb_pkg::RCP_STEPS];
   logic [2:0]                               rc_sat_in;
   side_type                                 rc_side_in;

   // Slab section.
   logic                                     t1_vld_ff, t2_vld_ff, t3_vld_ff;
   logic                                     t4_vld_ff, t5_vld_ff, t6_vld_ff;
   logic [5:0][rabb_pkg::DIFF_W-1:0]         t1_dmag_ff;
   logic [5:0]                               t1_sgn_ff, t2_sgn_ff, t3_sgn_ff;
   logic [2:0][rabb_pkg::INV_W-1:0]          t1_inv_ff;
   logic [5:0][rabb_pkg::PPL_W-1:0]          t2_lo_ff;
   logic [5:0][rabb_pkg::PPH_W-1:0]          t2_hi_ff;
   logic [5:0][rabb_pkg::T_W-1:0]            t3_m_ff;
   logic signed [rabb_pkg::T_W-1:0]          t4_t_ff    [0:5];
   logic signed [rabb_pkg::T_W-1:0]          t5_near_ff [0:2];
   logic signed [rabb_pkg::T_W-1:0]          t5_far_ff  [0:2];
   logic signed [rabb_pkg::T_W-1:0]          t6_tmin_ff, t6_tmax_ff;
   logic signed [rabb_pkg::T_W-1:0]          near01, far01, tmin_in, tmax_in;

   // Result register.
   logic                                     rsp_valid_ff;
   rabb_pkg::ray_rsp_type                    rsp_data_ff;
   rabb_pkg::ray_rsp_type                    rsp_data_in;

   // The whole pipeline moves when the result register is free or drained.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign req_take  = req_valid && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Box register writes; indexes past the last corner are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rabb_pkg::NUM_CSR; i++) begin
            box_ff[i] <= '0;
         end
      end else if (csr_wr_en && csr_index <= rabb_pkg::CSR_BOX_MAX_Z) begin
         box_ff[csr_index] <= csr_wr_data;
      end
   end

   // Stage 1: direction signs and magnitudes.
   always_comb begin
      logic [2:0][rabb_pkg::COORD_W-1:0] dir;
      dir[0] = req_data.ray_dir_x;
      dir[1] = req_data.ray_dir_y;
      dir[2] = req_data.ray_dir_z;
      s1_side_in.org[0] = req_data.ray_origin_x;
      s1_side_in.org[1] = req_data.ray_origin_y;
      s1_side_in.org[2] = req_data.ray_origin_z;
      s1_side_in.zero   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         s1_side_in.neg[i] = dir[i][rabb_pkg::COORD_W-1];
         s1_mag_in[i]      = s1_side_in.neg[i] ? (~dir[i] + 1'b1) : dir[i];
      end
   end

   // Stage 2: largest magnitude, and whether the direction is all zero.
   always_comb begin
      s2_big_in = s1_mag_ff[0];
      if (s1_mag_ff[1] > s2_big_in) begin
         s2_big_in = s1_mag_ff[1];
      end
      if (s1_mag_ff[2] > s2_big_in) begin
         s2_big_in = s1_mag_ff[2];
      end
      s2_side_in      = s1_side_ff;
      s2_side_in.zero = (s2_big_in == '0);
   end

   // Stage 3: shift all three so the largest lies just below 2^30.
   always_comb begin
      logic [rabb_pkg::COORD_W-1:0] shifted;
      msb_pos = '0;
      for (int i = 0; i < rabb_pkg::COORD_W; i++) begin
         if (s2_big_ff[i]) begin
            msb_pos = 5'(i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (msb_pos >= 5'(rabb_pkg::MAG_W)) begin
            shifted = s2_mag_ff[i] >> (msb_pos - 5'(rabb_pkg::MAG_W - 1));
         end else begin
            shifted = s2_mag_ff[i] << (5'(rabb_pkg::MAG_W - 1) - msb_pos);
         end
         s3_mag_in[i] = shifted[rabb_pkg::MAG_W-1:0];
      end
   end

   // Front stage registers; stage 5 loads the square root section input.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_take;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         sq_vld_ff[0] <= s4_vld_ff;
      end
      if (adv) begin
         s1_side_ff      <= s1_side_in;
         s1_mag_ff       <= s1_mag_in;
         s2_side_ff      <= s2_side_in;
         s2_mag_ff       <= s1_mag_ff;
         s2_big_ff       <= s2_big_in;
         s3_side_ff      <= s2_side_ff;
         s3_mag_ff       <= s3_mag_in;
         s4_side_ff      <= s3_side_ff;
         s4_mag_ff       <= s3_mag_ff;
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= rabb_pkg::SQR_W'(s3_mag_ff[i]) * rabb_pkg::SQR_W'(s3_mag_ff[i]);
         end
         sq_x_ff[0]    <= rabb_pkg::SUM_W'(s4_sq_ff[0]) + rabb_pkg::SUM_W'(s4_sq_ff[1])
                          + rabb_pkg::SUM_W'(s4_sq_ff[2]);
         sq_res_ff[0]  <= '0;
         sq_mag_ff[0]  <= s4_mag_ff;
         sq_side_ff[0] <= s4_side_ff;
      end
   end

   // Square root, one result bit per stage.
   for (genvar k = 0; k < rabb_pkg::SQ_STEPS; k++) begin : g_sqrt
      localparam logic [rabb_pkg::SUM_W-1:0] BitVal =
         rabb_pkg::SUM_W'(1) << (rabb_pkg::SUM_W - 2 - 2 * k);
      logic [rabb_pkg::SUM_W:0]   trial;
      logic [rabb_pkg::SUM_W-1:0] x_in, res_in;

      always_comb begin
         trial = {1'b0, sq_res_ff[k]} + {1'b0, BitVal};
         if ({1'b0, sq_x_ff[k]} >= trial) begin
            x_in   = sq_x_ff[k] - trial[rabb_pkg::SUM_W-1:0];
            res_in = (sq_res_ff[k] >> 1) + BitVal;
         end else begin
            x_in   = sq_x_ff[k];
            res_in = sq_res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         if (adv) begin
            sq_x_ff[k+1]    <= x_in;
            sq_res_ff[k+1]  <= res_in;
            sq_mag_ff[k+1]  <= sq_mag_ff[k];
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // Normal divider input: remainder starts with the top dividend bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[rabb_pkg::SQ_STEPS];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= rabb_pkg::LEN_W'(sq_mag_ff[rabb_pkg::SQ_STEPS][i] >> 1);
            dv_lsb_ff[i]    <= sq_mag_ff[rabb_pkg::SQ_STEPS][i][0];
         end
         dv_q_ff[0]    <= '0;
         dv_len_ff[0]  <= sq_res_ff[rabb_pkg::SQ_STEPS][rabb_pkg::LEN_W-1:0];
         dv_side_ff[0] <= sq_side_ff[rabb_pkg::SQ_STEPS];
      end
   end

   // Normal divider, one quotient bit per stage in each lane.
   for (genvar k = 0; k < rabb_pkg::DIV_STEPS; k++) begin : g_div
      logic [2:0][rabb_pkg::LEN_W-1:0] rem_in;
      logic [2:0][rabb_pkg::NRM_W-1:0] q_in;

      always_comb begin
         logic [rabb_pkg::LEN_W:0] part;
         logic                     dbit;
         for (int i = 0; i < 3; i++) begin
            dbit = (k == 0) ? dv_lsb_ff[i] : 1'b0;
            part = {dv_rem_ff[k][i], dbit};
            if (part >= {1'b0, dv_len_ff[k]}) begin
               part      = part - {1'b0, dv_len_ff[k]};
               q_in[i]   = {dv_q_ff[k][i][rabb_pkg::NRM_W-2:0], 1'b1};
            end else begin
               q_in[i]   = {dv_q_ff[k][i][rabb_pkg::NRM_W-2:0], 1'b0};
            end
            rem_in[i] = part[rabb_pkg::LEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         if (adv) begin
            dv_rem_ff[k+1]  <= rem_in;
            dv_q_ff[k+1]    <= q_in;
            dv_len_ff[k+1]  <= dv_len_ff[k];
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
      end
   end

   // Reciprocal divider input; a zero normal saturates and counts as positive.
   always_comb begin
      rc_side_in = dv_side_ff[rabb_pkg::DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
         rc_sat_in[i]      = dv_side_ff[rabb_pkg::DIV_STEPS].zero
                             || (dv_q_ff[rabb_pkg::DIV_STEPS][i] == '0);
         rc_side_in.neg[i] = dv_side_ff[rabb_pkg::DIV_STEPS].neg[i] && !rc_sat_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         rc_vld_ff[0] <= dv_vld_ff[rabb_pkg::DIV_STEPS];
      end
      if (adv) begin
         rc_side_ff[0] <= rc_side_in;
         rc_sat_ff[0]  <= rc_sat_in;
         rc_div_ff[0]  <= dv_q_ff[rabb_pkg::DIV_STEPS];
         rc_rem_ff[0]  <= '0;
         rc_q_ff[0]    <= '0;
      end
   end

   // Reciprocal divider, one quotient bit per stage in each lane.
   for (genvar k = 0; k < rabb_pkg::RCP_STEPS; k++) begin : g_rcp
      logic [2:0][rabb_pkg::NRM_W-1:0] rem_in;
      logic [2:0][rabb_pkg::INV_W-1:0] q_in;

      always_comb begin
         logic [rabb_pkg::NRM_W:0] part;
         for (int i = 0; i < 3; i++) begin
            part = {rc_rem_ff[k][i], (k == 0) ? 1'b1 : 1'b0};
            if (part >= {1'b0, rc_div_ff[k][i]}) begin
               part    = part - {1'b0, rc_div_ff[k][i]};
               q_in[i] = {rc_q_ff[k][i][rabb_pkg::INV_W-2:0], 1'b1};
            end else begin
               q_in[i] = {rc_q_ff[k][i][rabb_pkg::INV_W-2:0], 1'b0};
            end
            rem_in[i] = part[rabb_pkg::NRM_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rc_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            rc_vld_ff[k+1] <= rc_vld_ff[k];
         end
         if (adv) begin
            rc_rem_ff[k+1]  <= rem_in;
            rc_q_ff[k+1]    <= q_in;
            rc_div_ff[k+1]  <= rc_div_ff[k];
            rc_sat_ff[k+1]  <= rc_sat_ff[k];
            rc_side_ff[k+1] <= rc_side_ff[k];
         end
      end
   end

   // Slab section valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
         t4_vld_ff <= 1'b0;
         t5_vld_ff <= 1'b0;
         t6_vld_ff <= 1'b0;
      end else if (adv) begin
         t1_vld_ff <= rc_vld_ff[rabb_pkg::RCP_STEPS];
         t2_vld_ff <= t1_vld_ff;
         t3_vld_ff <= t2_vld_ff;
         t4_vld_ff <= t3_vld_ff;
         t5_vld_ff <= t4_vld_ff;
         t6_vld_ff <= t5_vld_ff;
      end
   end

   // Final reciprocals with the saturated value for zero normals.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            t1_inv_ff[i] <= rc_sat_ff[rabb_pkg::RCP_STEPS][i] ? rabb_pkg::RECIP_SAT
                                                               : rc_q_ff[rabb_pkg::RCP_STEPS][i];
         end
      end
   end

   // Per-slab distance: lower corners in slabs 0 to 2, upper corners in 3 to 5.
   for (genvar j = 0; j < 6; j++) begin : g_slab
      localparam int Ax = j % 3;
      logic signed [rabb_pkg::DIFF_W-1:0] diff;
      logic [rabb_pkg::T_W-1:0]           mag_sat;

      always_comb begin
         diff = rabb_pkg::DIFF_W'($signed(box_ff[j]))
                - rabb_pkg::DIFF_W'($signed(rc_side_ff[rabb_pkg::RCP_STEPS].org[Ax]));
         mag_sat = (t3_m_ff[j] > rabb_pkg::T_SAT) ? rabb_pkg::T_SAT : t3_m_ff[j];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            // Magnitude and sign of the distance to the plane.
            t1_dmag_ff[j] <= diff[rabb_pkg::DIFF_W-1] ? -diff : diff;
            t1_sgn_ff[j]  <= diff[rabb_pkg::DIFF_W-1]
                             ^ rc_side_ff[rabb_pkg::RCP_STEPS].neg[Ax];
            // Two partial products of the 33 by 61 bit product.
            t2_lo_ff[j]   <= rabb_pkg::PPL_W'(t1_dmag_ff[j])
                             * rabb_pkg::PPL_W'(t1_inv_ff[Ax][rabb_pkg::INV_LO_W-1:0]);
            t2_hi_ff[j]   <= rabb_pkg::PPH_W'(t1_dmag_ff[j])
                             * rabb_pkg::PPH_W'(t1_inv_ff[Ax][rabb_pkg::INV_W-1:rabb_pkg::INV_LO_W]);
            t2_sgn_ff[j]  <= t1_sgn_ff[j];
            // Product scaled down by 2^30; the high part sits one bit above.
            t3_m_ff[j]    <= rabb_pkg::T_W'(t2_lo_ff[j] >> rabb_pkg::FRAC_W)
                             + {t2_hi_ff[j], 1'b0};
            t3_sgn_ff[j]  <= t2_sgn_ff[j];
            // Saturate and apply the sign.
            t4_t_ff[j]    <= t3_sgn_ff[j] ? -$signed(mag_sat) : $signed(mag_sat);
         end
      end
   end

   // Near and far distance per axis.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            if (t4_t_ff[a] < t4_t_ff[a+3]) begin
               t5_near_ff[a] <= t4_t_ff[a];
               t5_far_ff[a]  <= t4_t_ff[a+3];
            end else begin
               t5_near_ff[a] <= t4_t_ff[a+3];
               t5_far_ff[a]  <= t4_t_ff[a];
            end
         end
      end
   end

   // Entry is the latest near distance, exit the earliest far distance.
   always_comb begin
      near01  = (t5_near_ff[0] > t5_near_ff[1]) ? t5_near_ff[0] : t5_near_ff[1];
      tmin_in = (near01 > t5_near_ff[2]) ? near01 : t5_near_ff[2];
      far01   = (t5_far_ff[0] < t5_far_ff[1]) ? t5_far_ff[0] : t5_far_ff[1];
      tmax_in = (far01 < t5_far_ff[2]) ? far01 : t5_far_ff[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t6_tmin_ff <= tmin_in;
         t6_tmax_ff <= tmax_in;
      end
   end

   // Classification: entry behind the origin is checked before overlap.
   always_comb begin
      rsp_data_in = '0;
      if (t6_tmin_ff < 0) begin
         rsp_data_in.outcome = rabb_pkg::OUTCOME_BEHIND;
      end else if (t6_tmin_ff > t6_tmax_ff) begin
         rsp_data_in.outcome = rabb_pkg::OUTCOME_MISS;
      end else begin
         rsp_data_in.hit     = 1'b1;
         rsp_data_in.outcome = rabb_pkg::OUTCOME_HIT;
         if (t6_tmin_ff > rabb_pkg::T_W'(rabb_pkg::DIST_MAX)) begin
            rsp_data_in.hit_distance = rabb_pkg::DIST_MAX;
         end else begin
            rsp_data_in.hit_distance = t6_tmin_ff[rabb_pkg::DIST_W-1:0];
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= t6_vld_ff;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
